// ===== hdl/ftdt_pkg.sv =====
// ----------------------------------------------------------------------------
// Fixed-point to decimal text package
// Shared types and constants of the decimal text formatter.
// ----------------------------------------------------------------------------
package ftdt_pkg;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 8;
   localparam int PLACES_WIDTH    = 4;
   localparam int CHAR_WIDTH      = 8;
   localparam int QUEUE_DEPTH     = 2;

   localparam logic [PLACES_WIDTH-1:0] MAX_PLACES = 4'd8;
   localparam int MIN_DIGITS = 9;

   localparam logic [CHAR_WIDTH-1:0] CH_MINUS      = 8'd45;
   localparam logic [CHAR_WIDTH-1:0] CH_OPEN       = 8'd40;
   localparam logic [CHAR_WIDTH-1:0] CH_CLOSE      = 8'd41;
   localparam logic [CHAR_WIDTH-1:0] CH_ZERO       = 8'd48;
   localparam logic [CHAR_WIDTH-1:0] CH_POINT_INIT = 8'd46;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_DECIMAL_PLACES,
      REG_POINT_CHAR,
      REG_PRINT_ZEROS,
      REG_BRACKET_NEGATIVES
   } csr_index_type;

   typedef struct packed {
      logic [PLACES_WIDTH-1:0] places;
      logic [CHAR_WIDTH-1:0]   point_char;
      logic                    print_zeros;
      logic                    bracket_negatives;
   } cfg_type;

   typedef struct packed {
      logic neg;
      logic empty;
   } flags_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_PREP,
      ST_SIGN,
      ST_DIGIT,
      ST_POINT,
      ST_CLOSE,
      ST_EMPTY
   } back_state_type;

endpackage

// ===== hdl/ftdt_channels.sv =====
// ----------------------------------------------------------------------------
// Fixed-point to decimal text channels
// Valid/ready channels for amounts, characters and register writes.
// ----------------------------------------------------------------------------
interface ftdt_req_if #(parameter int AMOUNT_WIDTH = 32) ();
   logic                           valid;
   logic                           ready;
   logic signed [AMOUNT_WIDTH-1:0] amount;
   logic                           use_zero_override;
   logic                           zero_override;

   modport source(output valid, amount, use_zero_override, zero_override, input ready);
   modport sink(input valid, amount, use_zero_override, zero_override, output ready);
endinterface

interface ftdt_rsp_if import ftdt_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CHAR_WIDTH-1:0] text_char;
   logic                  is_empty;
   logic                  last_char;

   modport source(output valid, text_char, is_empty, last_char, input ready);
   modport sink(input valid, text_char, is_empty, last_char, output ready);
endinterface

interface ftdt_csr_if import ftdt_pkg::*; ();
   logic                      valid;
   logic                      ready;
   csr_index_type             index;
   logic [CSR_DATA_WIDTH-1:0] data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

// ===== hdl/ftdt_front.sv =====
// ----------------------------------------------------------------------------
// Decimal text front end
// Holds the registers, takes amounts and classifies them for the back end.
// ----------------------------------------------------------------------------
module ftdt_front import ftdt_pkg::*; #(
   parameter int AMOUNT_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   ftdt_req_if.sink                req,
   ftdt_csr_if.sink                csr,
   output cfg_type                 cfg,
   output logic                    q_push,
   output logic [AMOUNT_WIDTH-1:0] q_mag,
   output flags_type               q_flags,
   input  logic                    q_full
);

   logic [PLACES_WIDTH-1:0] places_ff;
   logic [CHAR_WIDTH-1:0]   point_ff;
   logic                    zeros_ff;
   logic                    bracket_ff;
   logic                    neg;
   logic                    zeros;

   always_ff @(posedge clock) begin
      if (reset) begin
         places_ff  <= '0;
         point_ff   <= CH_POINT_INIT;
         zeros_ff   <= 1'b0;
         bracket_ff <= 1'b0;
      end else if (csr.valid) begin
         case (csr.index)
            REG_DECIMAL_PLACES:    places_ff  <= csr.data[PLACES_WIDTH-1:0];
            REG_POINT_CHAR:        point_ff   <= csr.data[CHAR_WIDTH-1:0];
            REG_PRINT_ZEROS:       zeros_ff   <= csr.data[0];
            REG_BRACKET_NEGATIVES: bracket_ff <= csr.data[0];
            default: begin
            end
         endcase
      end
   end

   assign csr.ready = 1'b1;

   always_comb begin
      cfg.places            = (places_ff > MAX_PLACES) ? MAX_PLACES : places_ff;
      cfg.point_char        = point_ff;
      cfg.print_zeros       = zeros_ff;
      cfg.bracket_negatives = bracket_ff;
   end

   assign neg   = req.amount[AMOUNT_WIDTH-1];
   assign zeros = req.use_zero_override ? req.zero_override : zeros_ff;
   assign q_mag = neg ? (~req.amount + 1'b1) : req.amount;

   always_comb begin
      q_flags.neg   = neg;
      q_flags.empty = (req.amount == '0) && !zeros;
   end

   assign req.ready = !q_full;
   assign q_push    = req.valid && !q_full;

endmodule

// ===== hdl/ftdt_queue.sv =====
// ----------------------------------------------------------------------------
// Decimal text item queue
// Short first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module ftdt_queue import ftdt_pkg::*; #(
   parameter int DATA_WIDTH = 34
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [DATA_WIDTH-1:0] push_data,
   output logic                  full,
   input  logic                  pop,
   output logic [DATA_WIDTH-1:0] pop_data,
   output logic                  not_empty
);

   localparam int PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   logic [DATA_WIDTH-1:0] mem_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]  wr_ptr_ff;
   logic [PTR_WIDTH-1:0]  wr_ptr_in;
   logic [PTR_WIDTH-1:0]  rd_ptr_ff;
   logic [PTR_WIDTH-1:0]  rd_ptr_in;
   logic [CNT_WIDTH-1:0]  count_ff;
   logic [CNT_WIDTH-1:0]  count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data  = mem_ff[rd_ptr_ff];
   assign full      = (count_ff == CNT_WIDTH'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> count_ff != CNT_WIDTH'(QUEUE_DEPTH))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("queue read while empty");

endmodule

// ===== hdl/ftdt_back.sv =====
// ----------------------------------------------------------------------------
// Decimal text back end
// Converts a magnitude to decimal one bit a cycle and emits the characters.
// ----------------------------------------------------------------------------
module ftdt_back import ftdt_pkg::*; #(
   parameter int AMOUNT_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cfg_type                 cfg,
   input  logic                    q_valid,
   input  logic [AMOUNT_WIDTH-1:0] q_mag,
   input  flags_type               q_flags,
   output logic                    q_pop,
   ftdt_rsp_if.source              rsp
);

   localparam int NDIG      = (AMOUNT_WIDTH * 3) / 10 + 1;
   localparam int NBCD      = (NDIG > MIN_DIGITS) ? NDIG : MIN_DIGITS;
   localparam int POS_WIDTH = $clog2(NBCD);
   localparam int CNT_WIDTH = $clog2(AMOUNT_WIDTH);

   back_state_type                state_ff;
   back_state_type                state_in;
   logic [AMOUNT_WIDTH-1:0]       mag_ff;
   logic [AMOUNT_WIDTH-1:0]       mag_in;
   logic [NBCD-1:0][3:0]          bcd_ff;
   logic [NBCD-1:0][3:0]          bcd_in;
   logic [NBCD-1:0][3:0]          bcd_step;
   logic [NBCD-1:0][3:0]          bcd_adj;
   logic [CNT_WIDTH-1:0]          cnt_ff;
   logic [CNT_WIDTH-1:0]          cnt_in;
   logic                          neg_ff;
   logic                          neg_in;
   logic [POS_WIDTH-1:0]          pos_ff;
   logic [POS_WIDTH-1:0]          pos_in;
   logic [POS_WIDTH-1:0]          hi_pos;
   logic [POS_WIDTH-1:0]          top_pos;
   logic                          rsp_valid_ff;
   logic [CHAR_WIDTH-1:0]         rsp_char_ff;
   logic                          rsp_empty_ff;
   logic                          rsp_last_ff;
   logic                          out_free;
   logic                          out_load;
   logic [CHAR_WIDTH-1:0]         out_char;
   logic                          out_empty;
   logic                          out_last;
   logic                          brackets;

   assign brackets = neg_ff && cfg.bracket_negatives;
   assign out_free = !rsp_valid_ff || rsp.ready;

   // Double dabble: correct every digit, then shift in the next magnitude bit.
   always_comb begin
      for (int i = 0; i < NBCD; i++) begin
         bcd_adj[i] = (bcd_ff[i] >= 4'd5) ? bcd_ff[i] + 4'd3 : bcd_ff[i];
      end
      bcd_step[0] = {bcd_adj[0][2:0], mag_ff[AMOUNT_WIDTH-1]};
      for (int i = 1; i < NBCD; i++) begin
         bcd_step[i] = {bcd_adj[i][2:0], bcd_adj[i-1][3]};
      end
   end

   always_comb begin
      hi_pos = '0;
      for (int i = 0; i < NBCD; i++) begin
         if (bcd_ff[i] != 4'd0) begin
            hi_pos = POS_WIDTH'(i);
         end
      end
      top_pos = (hi_pos > POS_WIDTH'(cfg.places)) ? hi_pos : POS_WIDTH'(cfg.places);
   end

   always_comb begin
      state_in  = state_ff;
      mag_in    = mag_ff;
      bcd_in    = bcd_ff;
      cnt_in    = cnt_ff;
      neg_in    = neg_ff;
      pos_in    = pos_ff;
      q_pop     = 1'b0;
      out_load  = 1'b0;
      out_char  = '0;
      out_empty = 1'b0;
      out_last  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               neg_in   = q_flags.neg;
               mag_in   = q_mag;
               bcd_in   = '0;
               cnt_in   = '0;
               state_in = q_flags.empty ? ST_EMPTY : ST_CONV;
            end
         end
         ST_CONV: begin
            bcd_in = bcd_step;
            mag_in = {mag_ff[AMOUNT_WIDTH-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_WIDTH'(AMOUNT_WIDTH - 1)) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            pos_in   = top_pos;
            state_in = neg_ff ? ST_SIGN : ST_DIGIT;
         end
         ST_SIGN: begin
            if (out_free) begin
               out_load = 1'b1;
               out_char = cfg.bracket_negatives ? CH_OPEN : CH_MINUS;
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (out_free) begin
               out_load = 1'b1;
               out_char = CH_ZERO + CHAR_WIDTH'(bcd_ff[pos_ff]);
               out_last = (pos_ff == '0) && !brackets;
               if (pos_ff == '0) begin
                  state_in = brackets ? ST_CLOSE : ST_IDLE;
               end else begin
                  pos_in = pos_ff - 1'b1;
                  if ((cfg.places != '0) && (pos_ff == POS_WIDTH'(cfg.places))) begin
                     state_in = ST_POINT;
                  end
               end
            end
         end
         ST_POINT: begin
            if (out_free) begin
               out_load = 1'b1;
               out_char = cfg.point_char;
               state_in = ST_DIGIT;
            end
         end
         ST_CLOSE: begin
            if (out_free) begin
               out_load = 1'b1;
               out_char = CH_CLOSE;
               out_last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_EMPTY: begin
            if (out_free) begin
               out_load  = 1'b1;
               out_empty = 1'b1;
               out_last  = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      pos_ff <= pos_in;
      if (out_load) begin
         rsp_char_ff  <= out_char;
         rsp_empty_ff <= out_empty;
         rsp_last_ff  <= out_last;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.text_char = rsp_char_ff;
   assign rsp.is_empty  = rsp_empty_ff;
   assign rsp.last_char = rsp_last_ff;

   a_digit_decimal: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIGIT |-> bcd_ff[pos_ff] <= 4'd9)
      else $error("converted digit out of decimal range");

   a_empty_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_empty_ff |-> rsp_last_ff && (rsp_char_ff == '0))
      else $error("empty beat is not a lone final beat");

   a_pop_when_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> state_ff == ST_IDLE && q_valid)
      else $error("queue read outside of idle");

endmodule

// ===== hdl/fixed_point_to_decimal_text_unit.sv =====
// Each amount is converted by the one-bit-a-cycle binary to decimal shift and then gives N characters
// (1 to 13 at 32 bits); the back end takes the next amount only after its last character is loaded.
// A two-beat queue lets the front take amounts while the back end converts or stalls.
// Reset is synchronous; it empties the queue and output and restores the register defaults.
// ----------------------------------------------------------------------------
// Fixed-point to decimal text unit
// Formats signed scaled amounts as ASCII text, one character per beat.
// ----------------------------------------------------------------------------
module fixed_point_to_decimal_text_unit import ftdt_pkg::*; #(
   parameter int AMOUNT_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   ftdt_req_if.sink   req_chan,
   ftdt_rsp_if.source rsp_chan,
   ftdt_csr_if.sink   csr_chan
);

   localparam int ITEM_WIDTH = AMOUNT_WIDTH + $bits(flags_type);

   cfg_type                 cfg;
   logic                    push;
   logic [AMOUNT_WIDTH-1:0] push_mag;
   flags_type               push_flags;
   logic                    q_full;
   logic                    q_pop;
   logic                    q_valid;
   logic [ITEM_WIDTH-1:0]   q_data;
   flags_type               q_flags;

   ftdt_front #(.AMOUNT_WIDTH(AMOUNT_WIDTH)) u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_chan),
      .csr     (csr_chan),
      .cfg     (cfg),
      .q_push  (push),
      .q_mag   (push_mag),
      .q_flags (push_flags),
      .q_full  (q_full)
   );

   ftdt_queue #(.DATA_WIDTH(ITEM_WIDTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_flags, push_mag}),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_data),
      .not_empty (q_valid)
   );

   assign q_flags = q_data[ITEM_WIDTH-1:AMOUNT_WIDTH];

   ftdt_back #(.AMOUNT_WIDTH(AMOUNT_WIDTH)) u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .q_valid (q_valid),
      .q_mag   (q_data[AMOUNT_WIDTH-1:0]),
      .q_flags (q_flags),
      .q_pop   (q_pop),
      .rsp     (rsp_chan)
   );

endmodule
